[design/fccp_pkg.sv]
// Shared types, codes and helpers for the friction cone projection block.
// No dependencies; used by the top level.
`timescale 1ns / 1ps
`default_nettype none

package fccp_pkg;

  // Configuration register indexes
  localparam logic REG_FLUID_COHESION = 1'b0;
  localparam logic REG_FLUID_FRICTION = 1'b1;

  // Outcome of the cone test
  typedef enum logic [1:0] {
    CASE_FREE    = 2'd0,
    CASE_INSIDE  = 2'd1,
    CASE_ZERO    = 2'd2,
    CASE_SURFACE = 2'd3
  } proj_case_e;

  // Side data carried through the square root pipeline
  typedef struct packed {
    logic signed [31:0] u;
    logic signed [31:0] v;
    logic signed [31:0] s;
    logic [30:0]        c;
    logic [30:0]        mu;
    logic [61:0]        mumu;
  } sq_side_t;

  // Side data carried through the first divider
  typedef struct packed {
    logic signed [31:0] u;
    logic signed [31:0] v;
    logic [30:0]        c;
    logic [30:0]        mu;
    logic [31:0]        f;
    logic signed [31:0] rn;
    proj_case_e         kase;
    logic               ovf;
  } dv1_side_t;

  // Side data carried through the second divider
  typedef struct packed {
    logic signed [31:0] u;
    logic signed [31:0] v;
    logic [30:0]        c;
    logic [30:0]        sp;
    logic signed [31:0] rn;
    proj_case_e         kase;
    logic               ovf;
  } dv2_side_t;

  // Saturate a 33-bit signed value to 32 bits
  function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
    logic signed [31:0] r;
    r = x[31:0];
    if (x[32:31] == 2'b01) r = 32'sh7FFF_FFFF;
    else if (x[32:31] == 2'b10) r = 32'sh8000_0000;
    return r;
  endfunction

endpackage

`default_nettype wire

[design/fccp_isqrt.sv]
// Pipelined integer square root of a 64-bit value, two radicand bits per stage.
// Carries a side vector along with each request; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fccp_isqrt #(
  parameter int unsigned SIDE_W = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [63:0]       rad_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   valid_o,
  output logic [31:0]            root_o,
  output logic [SIDE_W-1:0]      side_o
);

  localparam int unsigned NS = 32;

  logic              vld_q  [NS];
  logic [33:0]       rem_q  [NS];
  logic [31:0]       root_q [NS];
  logic [63:0]       xs_q   [NS];
  logic [SIDE_W-1:0] side_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic              vld_cur;
    logic [33:0]       rem_cur;
    logic [31:0]       root_cur;
    logic [63:0]       xs_cur;
    logic [SIDE_W-1:0] side_cur;
    logic [35:0]       rem2;
    logic [35:0]       trial;
    logic [35:0]       diff;
    logic              ge;

    if (k == 0) begin : g_in
      assign vld_cur  = valid_i;
      assign rem_cur  = '0;
      assign root_cur = '0;
      assign xs_cur   = rad_i;
      assign side_cur = side_i;
    end else begin : g_mid
      assign vld_cur  = vld_q[k-1];
      assign rem_cur  = rem_q[k-1];
      assign root_cur = root_q[k-1];
      assign xs_cur   = xs_q[k-1];
      assign side_cur = side_q[k-1];
    end

    // One digit: bring down two bits, try root*4+1
    assign rem2  = {rem_cur, xs_cur[63:62]};
    assign trial = {2'b00, root_cur, 2'b01};
    assign ge    = rem2 >= trial;
    assign diff  = ge ? rem2 - trial : rem2;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_cur;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= diff[33:0];
        root_q[k] <= {root_cur[30:0], ge};
        xs_q[k]   <= {xs_cur[61:0], 2'b00};
        side_q[k] <= side_cur;
      end
    end

    // Remainder never exceeds twice the partial root
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      vld_q[k] |-> rem_q[k] <= {1'b0, root_q[k], 1'b0})
      else $error("isqrt remainder out of range");
  end

  assign valid_o = vld_q[NS-1];
  assign root_o  = root_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

`default_nettype wire

[design/fccp_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// The caller supplies a starting remainder below the divisor; no package use.
`timescale 1ns / 1ps
`default_nettype none

module fccp_div #(
  parameter int unsigned DEN_W  = 63,
  parameter int unsigned Q_W    = 31,
  parameter int unsigned SIDE_W = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [DEN_W-1:0]  rem_i,
  input  wire logic [Q_W-1:0]    low_i,
  input  wire logic [DEN_W-1:0]  den_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   valid_o,
  output logic [Q_W-1:0]         quo_o,
  output logic [SIDE_W-1:0]      side_o
);

  logic              vld_q  [Q_W];
  logic [DEN_W-1:0]  rem_q  [Q_W];
  logic [DEN_W-1:0]  den_q  [Q_W];
  logic [Q_W-1:0]    low_q  [Q_W];
  logic [Q_W-1:0]    quo_q  [Q_W];
  logic [SIDE_W-1:0] side_q [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic              vld_cur;
    logic [DEN_W-1:0]  rem_cur;
    logic [DEN_W-1:0]  den_cur;
    logic [Q_W-1:0]    low_cur;
    logic [Q_W-1:0]    quo_cur;
    logic [SIDE_W-1:0] side_cur;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    if (k == 0) begin : g_in
      assign vld_cur  = valid_i;
      assign rem_cur  = rem_i;
      assign den_cur  = den_i;
      assign low_cur  = low_i;
      assign quo_cur  = '0;
      assign side_cur = side_i;
    end else begin : g_mid
      assign vld_cur  = vld_q[k-1];
      assign rem_cur  = rem_q[k-1];
      assign den_cur  = den_q[k-1];
      assign low_cur  = low_q[k-1];
      assign quo_cur  = quo_q[k-1];
      assign side_cur = side_q[k-1];
    end

    // Shift in the next dividend bit, subtract when it fits
    assign trial = {rem_cur, low_cur[Q_W-1]};
    assign ge    = trial >= {1'b0, den_cur};
    assign diff  = ge ? trial - {1'b0, den_cur} : trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_cur;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= diff[DEN_W-1:0];
        den_q[k]  <= den_cur;
        low_q[k]  <= low_cur << 1;
        quo_q[k]  <= {quo_cur[Q_W-2:0], ge};
        side_q[k] <= side_cur;
      end
    end

    // Partial remainder stays below the divisor once it is nonzero
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      vld_q[k] && (den_q[k] != '0) |-> rem_q[k] < den_q[k])
      else $error("divider remainder not below divisor");
  end

  assign valid_o = vld_q[Q_W-1];
  assign quo_o   = quo_q[Q_W-1];
  assign side_o  = side_q[Q_W-1];

endmodule

`default_nettype wire

[design/friction_cone_projection_cohesion.sv]
// Coulomb friction cone projection with cohesion for one contact per request.
// Fully pipelined: one request per clock while the output is not stalled.
// The 32-stage square root and two bit-serial dividers (31 and 32 stages) are
// laid out as pipeline stages. A stalled output freezes the whole pipeline;
// nothing is lost or repeated. Config writes take effect for requests accepted
// afterwards. Depends on fccp_pkg, fccp_isqrt and fccp_div.
`timescale 1ns / 1ps
`default_nettype none

module friction_cone_projection_cohesion (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // config
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic               cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  // request
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [31:0] impulse_normal_in_i,
  input  wire logic signed [31:0] impulse_tan_u_in_i,
  input  wire logic signed [31:0] impulse_tan_v_in_i,
  input  wire logic [30:0]        body_friction_i,
  input  wire logic signed [31:0] body_cohesion_i,
  // result
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      impulse_normal_out_o,
  output logic signed [31:0]      impulse_tan_u_out_o,
  output logic signed [31:0]      impulse_tan_v_out_o,
  output logic [1:0]              projection_case_o
);

  logic en;

  // Config registers
  logic signed [31:0] fc_q;
  logic [30:0]        ff_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q <= '0;
      ff_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == fccp_pkg::REG_FLUID_COHESION) fc_q <= cfg_data_i;
      if (cfg_index_i == fccp_pkg::REG_FLUID_FRICTION) ff_q <= cfg_data_i[30:0];
    end
  end

  // Whole pipeline advances unless the result is held
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Stage A: cohesion, friction, tangential squares
  logic signed [32:0] coh_sum;
  logic [31:0]        fr_sum;
  logic               a_vld_q;
  logic signed [31:0] a_n_q, a_u_q, a_v_q;
  logic [30:0]        a_c_q, a_mu_q;
  logic [62:0]        a_uu_q, a_vv_q;
  logic signed [63:0] uu_d, vv_d;

  assign coh_sum = {body_cohesion_i[31], body_cohesion_i} + {fc_q[31], fc_q};
  assign fr_sum  = {1'b0, body_friction_i} + {1'b0, ff_q};
  assign uu_d    = impulse_tan_u_in_i * impulse_tan_u_in_i;
  assign vv_d    = impulse_tan_v_in_i * impulse_tan_v_in_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_vld_q <= 1'b0;
    else if (en) a_vld_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_n_q  <= impulse_normal_in_i;
      a_u_q  <= impulse_tan_u_in_i;
      a_v_q  <= impulse_tan_v_in_i;
      a_c_q  <= (!coh_sum[32] && (coh_sum != '0)) ? coh_sum[31:1] : '0;
      a_mu_q <= (body_friction_i == '0 || ff_q == '0) ? '0 : fr_sum[31:1];
      a_uu_q <= uu_d[62:0];
      a_vv_q <= vv_d[62:0];
    end
  end

  // Stage B: shifted normal, radicand, mu squared
  logic               b_vld_q;
  logic [63:0]        b_x_q;
  fccp_pkg::sq_side_t b_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_vld_q <= 1'b0;
    else if (en) b_vld_q <= a_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_x_q         <= {1'b0, a_uu_q} + {1'b0, a_vv_q};
      b_side_q.u    <= a_u_q;
      b_side_q.v    <= a_v_q;
      b_side_q.s    <= fccp_pkg::sat33({a_n_q[31], a_n_q} + {2'b00, a_c_q});
      b_side_q.c    <= a_c_q;
      b_side_q.mu   <= a_mu_q;
      b_side_q.mumu <= 62'(a_mu_q) * 62'(a_mu_q);
    end
  end

  // Tangential magnitude
  logic                              sq_vld;
  logic [31:0]                       sq_root;
  logic [$bits(fccp_pkg::sq_side_t)-1:0] sq_side_bits;
  fccp_pkg::sq_side_t                sq_side;

  fccp_isqrt #(
    .SIDE_W ($bits(fccp_pkg::sq_side_t))
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (b_vld_q),
    .rad_i   (b_x_q),
    .side_i  (b_side_q),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .side_o  (sq_side_bits)
  );

  assign sq_side = sq_side_bits;

  // Stage D: cone products
  logic               d_vld_q;
  logic [62:0]        d_muf_q;
  logic signed [63:0] d_mus_q;
  logic [31:0]        d_f_q;
  fccp_pkg::sq_side_t d_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) d_vld_q <= 1'b0;
    else if (en) d_vld_q <= sq_vld;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_muf_q  <= 63'(sq_side.mu) * 63'(sq_root);
      d_mus_q  <= $signed({1'b0, sq_side.mu}) * sq_side.s;
      d_f_q    <= sq_root;
      d_side_q <= sq_side;
    end
  end

  // Stage E: classify, build divider operands
  logic signed [31:0]   e_sc;
  logic [32:0]          e_negs;
  logic                 e_in_cone, e_dual;
  fccp_pkg::proj_case_e e_kase;
  logic signed [31:0]   e_rn;

  assign e_sc     = fccp_pkg::sat33({d_side_q.s[31], d_side_q.s} - {2'b00, d_side_q.c});
  assign e_negs   = 33'd0 - {d_side_q.s[31], d_side_q.s};
  assign e_in_cone = $signed({16'b0, d_f_q, 16'b0}) < d_mus_q;
  assign e_dual   = (d_side_q.s == '0) ||
                    (d_side_q.s[31] && (d_muf_q < {14'b0, e_negs, 16'b0}));

  always_comb begin
    e_kase = fccp_pkg::CASE_SURFACE;
    e_rn   = e_sc;
    priority if (d_side_q.mu == '0) begin
      e_kase = fccp_pkg::CASE_FREE;
      e_rn   = d_side_q.s[31] ? '0 : e_sc;
    end else if (e_in_cone) begin
      e_kase = fccp_pkg::CASE_INSIDE;
    end else if (e_dual) begin
      e_kase = fccp_pkg::CASE_ZERO;
      e_rn   = -$signed({1'b0, d_side_q.c});
    end else begin
      e_kase = fccp_pkg::CASE_SURFACE;
    end
  end

  logic                 e_vld_q;
  logic [63:0]          e_num_q;
  logic [62:0]          e_den_q;
  fccp_pkg::dv1_side_t  e_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) e_vld_q <= 1'b0;
    else if (en) e_vld_q <= d_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_num_q       <= {1'b0, d_muf_q} + {{16{d_side_q.s[31]}}, d_side_q.s, 16'b0};
      e_den_q       <= {1'b0, d_side_q.mumu} + 63'h1_0000_0000;
      e_side_q.u    <= d_side_q.u;
      e_side_q.v    <= d_side_q.v;
      e_side_q.c    <= d_side_q.c;
      e_side_q.mu   <= d_side_q.mu;
      e_side_q.f    <= d_f_q;
      e_side_q.rn   <= e_rn;
      e_side_q.kase <= e_kase;
      e_side_q.ovf  <= 1'b0;
    end
  end

  // Stage F: overflow test for the normal quotient
  logic                f_vld_q;
  logic [62:0]         f_rem_q, f_den_q;
  logic [30:0]         f_low_q;
  fccp_pkg::dv1_side_t f_side_q;
  fccp_pkg::dv1_side_t f_side_d;
  logic                f_ovf;

  assign f_ovf = {14'b0, e_num_q} >= {e_den_q, 15'b0};

  always_comb begin
    f_side_d     = e_side_q;
    f_side_d.ovf = f_ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) f_vld_q <= 1'b0;
    else if (en) f_vld_q <= e_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_rem_q  <= f_ovf ? '0 : {14'b0, e_num_q[63:15]};
      f_low_q  <= {e_num_q[14:0], 16'b0};
      f_den_q  <= e_den_q;
      f_side_q <= f_side_d;
    end
  end

  // Projected normal s'
  logic                                   dv1_vld;
  logic [30:0]                            dv1_q;
  logic [$bits(fccp_pkg::dv1_side_t)-1:0] dv1_side_bits;
  fccp_pkg::dv1_side_t                    dv1_side;

  fccp_div #(
    .DEN_W  (63),
    .Q_W    (31),
    .SIDE_W ($bits(fccp_pkg::dv1_side_t))
  ) u_div_normal (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_vld_q),
    .rem_i   (f_rem_q),
    .low_i   (f_low_q),
    .den_i   (f_den_q),
    .side_i  (f_side_q),
    .valid_o (dv1_vld),
    .quo_o   (dv1_q),
    .side_o  (dv1_side_bits)
  );

  assign dv1_side = dv1_side_bits;

  // Stage G: saturate s', form mu*s'
  logic                g_vld_q;
  logic [61:0]         g_musp_q;
  logic [31:0]         g_f_q;
  fccp_pkg::dv2_side_t g_side_q;
  logic [30:0]         g_sp;

  assign g_sp = dv1_side.ovf ? 31'h7FFF_FFFF : dv1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) g_vld_q <= 1'b0;
    else if (en) g_vld_q <= dv1_vld;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_musp_q      <= 62'(dv1_side.mu) * 62'(g_sp);
      g_f_q         <= dv1_side.f;
      g_side_q.u    <= dv1_side.u;
      g_side_q.v    <= dv1_side.v;
      g_side_q.c    <= dv1_side.c;
      g_side_q.sp   <= g_sp;
      g_side_q.rn   <= dv1_side.rn;
      g_side_q.kase <= dv1_side.kase;
      g_side_q.ovf  <= 1'b0;
    end
  end

  // Stage H: overflow test for the tangential ratio
  logic                h_vld_q;
  logic [31:0]         h_rem_q, h_low_q, h_den_q;
  fccp_pkg::dv2_side_t h_side_q;
  fccp_pkg::dv2_side_t h_side_d;
  logic                h_ovf;

  assign h_ovf = g_musp_q >= {14'b0, g_f_q, 16'b0};

  always_comb begin
    h_side_d     = g_side_q;
    h_side_d.ovf = h_ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) h_vld_q <= 1'b0;
    else if (en) h_vld_q <= g_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_rem_q  <= h_ovf ? '0 : g_musp_q[47:16];
      h_low_q  <= {g_musp_q[15:0], 16'b0};
      h_den_q  <= g_f_q;
      h_side_q <= h_side_d;
    end
  end

  // Ratio t in Q0.32
  logic                                   dv2_vld;
  logic [31:0]                            dv2_q;
  logic [$bits(fccp_pkg::dv2_side_t)-1:0] dv2_side_bits;
  fccp_pkg::dv2_side_t                    dv2_side;

  fccp_div #(
    .DEN_W  (32),
    .Q_W    (32),
    .SIDE_W ($bits(fccp_pkg::dv2_side_t))
  ) u_div_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (h_vld_q),
    .rem_i   (h_rem_q),
    .low_i   (h_low_q),
    .den_i   (h_den_q),
    .side_i  (h_side_q),
    .valid_o (dv2_vld),
    .quo_o   (dv2_q),
    .side_o  (dv2_side_bits)
  );

  assign dv2_side = dv2_side_bits;

  // Stage I: scale tangential magnitudes
  logic [31:0]          abs_u, abs_v, t_lo;
  logic                 i_vld_q;
  logic [63:0]          i_pu_q, i_pv_q;
  logic [31:0]          i_au_q, i_av_q;
  logic                 i_tfull_q, i_un_q, i_vn_q;
  logic signed [31:0]   i_u_q, i_v_q, i_rn_q, i_rn3_q;
  fccp_pkg::proj_case_e i_kase_q;

  assign abs_u = dv2_side.u[31] ? 32'(-dv2_side.u) : 32'(dv2_side.u);
  assign abs_v = dv2_side.v[31] ? 32'(-dv2_side.v) : 32'(dv2_side.v);
  assign t_lo  = dv2_side.ovf ? '0 : dv2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) i_vld_q <= 1'b0;
    else if (en) i_vld_q <= dv2_vld;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      i_pu_q    <= 64'(abs_u) * 64'(t_lo);
      i_pv_q    <= 64'(abs_v) * 64'(t_lo);
      i_au_q    <= abs_u;
      i_av_q    <= abs_v;
      i_tfull_q <= dv2_side.ovf;
      i_un_q    <= dv2_side.u[31];
      i_vn_q    <= dv2_side.v[31];
      i_u_q     <= dv2_side.u;
      i_v_q     <= dv2_side.v;
      i_rn_q    <= dv2_side.rn;
      i_rn3_q   <= $signed({1'b0, dv2_side.sp}) - $signed({1'b0, dv2_side.c});
      i_kase_q  <= dv2_side.kase;
    end
  end

  // Stage J: result register
  logic [31:0]          mag_u, mag_v;
  logic signed [31:0]   j_rn_d, j_ru_d, j_rv_d;
  logic                 j_vld_q;
  logic signed [31:0]   j_rn_q, j_ru_q, j_rv_q;
  fccp_pkg::proj_case_e j_kase_q;
  logic                 j_un_q;

  assign mag_u = i_tfull_q ? i_au_q : i_pu_q[63:32];
  assign mag_v = i_tfull_q ? i_av_q : i_pv_q[63:32];

  always_comb begin
    j_rn_d = i_rn_q;
    j_ru_d = '0;
    j_rv_d = '0;
    unique case (i_kase_q)
      fccp_pkg::CASE_FREE: begin
        j_rn_d = i_rn_q;
      end
      fccp_pkg::CASE_INSIDE: begin
        j_rn_d = i_rn_q;
        j_ru_d = i_u_q;
        j_rv_d = i_v_q;
      end
      fccp_pkg::CASE_ZERO: begin
        j_rn_d = i_rn_q;
      end
      fccp_pkg::CASE_SURFACE: begin
        j_rn_d = i_rn3_q;
        j_ru_d = i_un_q ? -$signed(mag_u) : $signed(mag_u);
        j_rv_d = i_vn_q ? -$signed(mag_v) : $signed(mag_v);
      end
      default: begin
        j_rn_d = i_rn_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) j_vld_q <= 1'b0;
    else if (en) j_vld_q <= i_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      j_rn_q   <= j_rn_d;
      j_ru_q   <= j_ru_d;
      j_rv_q   <= j_rv_d;
      j_kase_q <= i_kase_q;
      j_un_q   <= i_un_q;
    end
  end

  assign out_valid_o          = j_vld_q;
  assign impulse_normal_out_o = j_rn_q;
  assign impulse_tan_u_out_o  = j_ru_q;
  assign impulse_tan_v_out_o  = j_rv_q;
  assign projection_case_o    = j_kase_q;

  // Frictionless results carry no tangential impulse
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (projection_case_o == fccp_pkg::CASE_FREE) |->
      (impulse_tan_u_out_o == '0) && (impulse_tan_v_out_o == '0))
    else $error("frictionless result has tangential impulse");

  // Zeroed results carry no tangential impulse
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (projection_case_o == fccp_pkg::CASE_ZERO) |->
      (impulse_tan_u_out_o == '0) && (impulse_tan_v_out_o == '0))
    else $error("zeroed result has tangential impulse");

  // Surface projection keeps the direction of u
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (projection_case_o == fccp_pkg::CASE_SURFACE) &&
      (impulse_tan_u_out_o != '0) |-> impulse_tan_u_out_o[31] == j_un_q)
    else $error("projected u changed sign");

endmodule

`default_nettype wire
